// File: rtl/rrbc_pkg.sv
package rrbc_pkg;

   // Access kinds on the request channel.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_WRITE_DONE = 2'd0;
   localparam logic [1:0] KIND_ROM_FETCH  = 2'd1;
   localparam logic [1:0] KIND_READ_DATA  = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_NO_RAM   = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // Bus regions, selected by address bits 15:13.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_BANK_LOW   = 3'd1;
   localparam logic [2:0] REGION_BANK_HIGH  = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;
   localparam logic [2:0] REGION_RAM        = 3'd5;

   // Cartridge RAM size codes.
   localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
   localparam logic [1:0] RAM_SIZE_2K   = 2'd1;
   localparam logic [1:0] RAM_SIZE_8K   = 2'd2;
   localparam logic [1:0] RAM_SIZE_32K  = 2'd3;

   // Configuration register indexes.
   localparam logic REG_ROM_BANK_BITS = 1'b0;
   localparam logic REG_RAM_SIZE_CODE = 1'b1;

   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int ROM_ADDR_W     = 21;
   localparam int ROM_OFFSET_W   = 14;
   localparam int RAM_SPACE_W    = 15;
   localparam int RAM_OFFSET_W   = 13;

   localparam logic [2:0] ROM_BANK_BITS_RESET = 3'd7;
   localparam logic [3:0] RAM_ENABLE_KEY      = 4'hA;
   localparam logic [7:0] REFUSED_BYTE        = 8'hFF;

   typedef struct packed {
      logic [2:0] rom_bank_bits;
      logic [1:0] ram_size_code;
   } cfg_type;

endpackage

// File: rtl/rrbc_if.sv
interface rrbc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output command, output address, output write_data,
                   input ready);
   modport sink (input valid, input command, input address, input write_data,
                 output ready);
endinterface

interface rrbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [20:0] rom_address;
   logic [7:0]  read_data;
   logic [1:0]  status;

   modport source (output valid, output result_kind, output rom_address,
                   output read_data, output status, input ready);
   modport sink (input valid, input result_kind, input rom_address,
                 input read_data, input status, output ready);
endinterface

// File: rtl/rrbc_csr.sv
module rrbc_csr
   import rrbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [2:0] rom_bank_bits_ff;
   logic [2:0] rom_bank_bits_in;
   logic [1:0] ram_size_code_ff;
   logic [1:0] ram_size_code_in;
   logic       write_strobe;
   logic       reg_index;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite;
   assign reg_index    = paddr[2];

   always_comb begin
      rom_bank_bits_in = rom_bank_bits_ff;
      ram_size_code_in = ram_size_code_ff;
      if (write_strobe) begin
         case (reg_index)
            REG_ROM_BANK_BITS: rom_bank_bits_in = pwdata[2:0];
            REG_RAM_SIZE_CODE: ram_size_code_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_bits_ff <= ROM_BANK_BITS_RESET;
         ram_size_code_ff <= RAM_SIZE_NONE;
      end else begin
         rom_bank_bits_ff <= rom_bank_bits_in;
         ram_size_code_ff <= ram_size_code_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROM_BANK_BITS: prdata = {{(CSR_DATA_W-3){1'b0}}, rom_bank_bits_ff};
         REG_RAM_SIZE_CODE: prdata = {{(CSR_DATA_W-2){1'b0}}, ram_size_code_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.rom_bank_bits = rom_bank_bits_ff;
   assign cfg.ram_size_code = ram_size_code_ff;

endmodule

// File: rtl/rrbc_ram.sv
module rrbc_ram
   import rrbc_pkg::*;
#(
   parameter int RAM_BYTES = 32768
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          access_en,
   input  logic                          write_en,
   input  logic [$clog2(RAM_BYTES)-1:0]  addr,
   input  logic [7:0]                    wr_data,
   output logic [7:0]                    rd_data,
   output logic                          busy
);

   localparam int AW = $clog2(RAM_BYTES);

   logic [7:0]    mem [RAM_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] clear_ptr_ff;
   logic [AW-1:0] clear_ptr_in;
   logic          busy_ff;
   logic          busy_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   // The clearing pass owns the write port until every byte holds zero.
   always_comb begin
      clear_ptr_in = clear_ptr_ff;
      busy_in      = busy_ff;
      if (busy_ff) begin
         clear_ptr_in = clear_ptr_ff + 1'b1;
         if (clear_ptr_ff == {AW{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
         busy_ff      <= 1'b1;
      end else begin
         clear_ptr_ff <= clear_ptr_in;
         busy_ff      <= busy_in;
      end
   end

   assign mem_we = busy_ff || (access_en && write_en);
   assign mem_wa = busy_ff ? clear_ptr_ff : addr;
   assign mem_wd = busy_ff ? 8'h00 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (access_en && !write_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// File: rtl/rom_ram_bank_controller_unit.sv
// Bank controller for a cartridge bus: ROM banking registers plus internal cartridge RAM.
// Requests arrive on req_bus (command, address, write_data) and every accepted transfer
// produces exactly one transfer on rsp_bus (result_kind, rom_address, read_data, status).
// Writes below 0x8000 update the banking registers, reads below 0x8000 return the
// physical ROM address to fetch, and 0xA000-0xBFFF reach the cartridge RAM.
// The APB port sets the ROM size (register 0 at 0x0) and RAM size code (register 1
// at 0x4); it must only be written while no request is in flight.
// A request passes the decode stage, registered together with the synchronous RAM
// access, and then the output register before its result is valid.
// Throughput is one request per cycle unless the RAM is clearing or the receiver stalls;
// each item uses the single RAM port at most once, so back-to-back requests never collide.
// A write to a RAM byte lands at the edge of its transfer, so a read that follows
// in the next cycle already sees it.
// After reset the RAM is swept to zero, one byte a cycle, so req_bus.ready stays low
// until all RAM_BYTES bytes (32768 by default) are clear; APB writes are taken meanwhile.
// When the receiver stalls, the output register and the stage behind it both hold;
// one more request is taken while a result waits, then req_bus.ready drops.
module rom_ram_bank_controller_unit
   import rrbc_pkg::*;
#(
   parameter int RAM_BYTES = 32768
)
(
   input  logic                  clock,
   input  logic                  reset,
   rrbc_req_if.sink              req_bus,
   rrbc_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = $clog2(RAM_BYTES);

   cfg_type cfg;

   // Banking registers written from the CPU bus.
   logic       ram_enable_ff,   ram_enable_in;
   logic [4:0] bank_low_ff,     bank_low_in;
   logic [1:0] bank_high_ff,    bank_high_in;
   logic       banking_mode_ff, banking_mode_in;

   // Decode stage.
   logic                  accept;
   logic [2:0]            region;
   logic                  ram_fitted;
   logic [1:0]            ram_bank;
   logic [RAM_SPACE_W-1:0] ram_full;
   logic [RAM_SPACE_W-1:0] ram_mask;
   logic [AW-1:0]         ram_index;
   logic [6:0]            rom_bank;
   logic [ROM_ADDR_W-1:0] rom_full;
   logic [ROM_ADDR_W-1:0] rom_mask;
   logic [ROM_ADDR_W:0]   rom_span;
   logic [1:0]            dec_kind;
   logic [ROM_ADDR_W-1:0] dec_rom;
   logic [7:0]            dec_rdata;
   logic [1:0]            dec_status;
   logic                  dec_use_mem;
   logic                  mem_access;
   logic                  mem_write;
   logic [7:0]            mem_rd_data;
   logic                  mem_busy;

   // Stage behind the RAM read.
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_kind_ff;
   logic [ROM_ADDR_W-1:0] s1_rom_ff;
   logic [7:0]            s1_rdata_ff;
   logic [1:0]            s1_status_ff;
   logic                  s1_use_mem_ff;
   logic                  s1_advance;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_kind_ff;
   logic [ROM_ADDR_W-1:0] out_rom_ff;
   logic [7:0]            out_rdata_ff;
   logic [1:0]            out_status_ff;

   rrbc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The stage behind the RAM moves when the output register is free or being emptied.
   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !mem_busy && (!s1_valid_ff || s1_advance);
   assign accept        = req_bus.valid && req_bus.ready;

   assign region     = req_bus.address[15:13];
   assign ram_fitted = (cfg.ram_size_code != RAM_SIZE_NONE);

   // RAM address: bank (mode 1 only) above the 8 KiB window offset, wrapped to the
   // fitted size; the truncation to AW bits wraps to the storage size as well.
   assign ram_bank = banking_mode_ff ? bank_high_ff : 2'd0;
   assign ram_full = {ram_bank, req_bus.address[RAM_OFFSET_W-1:0]};

   always_comb begin
      case (cfg.ram_size_code)
         RAM_SIZE_2K:  ram_mask = 15'h07FF;
         RAM_SIZE_8K:  ram_mask = 15'h1FFF;
         RAM_SIZE_32K: ram_mask = 15'h7FFF;
         default:      ram_mask = 15'h0000;
      endcase
   end

   assign ram_index = ram_full[AW-1:0] & ram_mask[AW-1:0];

   // ROM address: fixed area bank 0 (high bank bits in mode 1); 0x4000 up: high:low bits.
   always_comb begin
      if (!req_bus.address[14]) begin
         rom_bank = banking_mode_ff ? {bank_high_ff, 5'd0} : 7'd0;
      end else begin
         rom_bank = {bank_high_ff, bank_low_ff};
      end
   end

   assign rom_full = {rom_bank, req_bus.address[ROM_OFFSET_W-1:0]};
   assign rom_span = (ROM_ADDR_W+1)'(1) << (ROM_OFFSET_W + int'(cfg.rom_bank_bits));
   assign rom_mask = ROM_ADDR_W'(rom_span - 1'b1);

   always_comb begin
      ram_enable_in   = ram_enable_ff;
      bank_low_in     = bank_low_ff;
      bank_high_in    = bank_high_ff;
      banking_mode_in = banking_mode_ff;
      dec_kind        = KIND_WRITE_DONE;
      dec_rom         = '0;
      dec_rdata       = 8'h00;
      dec_status      = STATUS_OK;
      dec_use_mem     = 1'b0;
      mem_access      = 1'b0;
      mem_write       = 1'b0;

      if (req_bus.command == CMD_WRITE) begin
         case (region)
            REGION_RAM_ENABLE: ram_enable_in = (req_bus.write_data[3:0] == RAM_ENABLE_KEY);
            REGION_BANK_LOW: begin
               // A low bank of zero selects bank one.
               if (req_bus.write_data[4:0] == 5'd0) begin
                  bank_low_in = 5'd1;
               end else begin
                  bank_low_in = req_bus.write_data[4:0];
               end
            end
            REGION_BANK_HIGH:  bank_high_in    = req_bus.write_data[1:0];
            REGION_MODE:       banking_mode_in = req_bus.write_data[0];
            REGION_RAM: begin
               if (!ram_enable_ff) begin
                  dec_status = STATUS_DISABLED;
               end else if (!ram_fitted) begin
                  dec_status = STATUS_NO_RAM;
               end else begin
                  mem_access = 1'b1;
                  mem_write  = 1'b1;
               end
            end
            default: dec_status = STATUS_RANGE;
         endcase
      end else if (!req_bus.address[15]) begin
         dec_kind = KIND_ROM_FETCH;
         dec_rom  = rom_full & rom_mask;
      end else begin
         dec_kind  = KIND_READ_DATA;
         dec_rdata = REFUSED_BYTE;
         if (region == REGION_RAM) begin
            if (!ram_enable_ff) begin
               dec_status = STATUS_DISABLED;
            end else if (!ram_fitted) begin
               dec_status = STATUS_NO_RAM;
            end else begin
               dec_use_mem = 1'b1;
               mem_access  = 1'b1;
            end
         end else begin
            dec_status = STATUS_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff   <= 1'b0;
         bank_low_ff     <= 5'd1;
         bank_high_ff    <= 2'd0;
         banking_mode_ff <= 1'b0;
      end else if (accept) begin
         ram_enable_ff   <= ram_enable_in;
         bank_low_ff     <= bank_low_in;
         bank_high_ff    <= bank_high_in;
         banking_mode_ff <= banking_mode_in;
      end
   end

   // The RAM read data stays put while the stage behind it stalls, because no new
   // access is issued until that stage moves on.
   rrbc_ram #(
      .RAM_BYTES (RAM_BYTES)
   ) u_ram (
      .clock     (clock),
      .reset     (reset),
      .access_en (accept && mem_access),
      .write_en  (mem_write),
      .addr      (ram_index),
      .wr_data   (req_bus.write_data),
      .rd_data   (mem_rd_data),
      .busy      (mem_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff    <= dec_kind;
         s1_rom_ff     <= dec_rom;
         s1_rdata_ff   <= dec_rdata;
         s1_status_ff  <= dec_status;
         s1_use_mem_ff <= dec_use_mem;
      end
      if (s1_advance) begin
         out_kind_ff   <= s1_kind_ff;
         out_rom_ff    <= s1_rom_ff;
         out_rdata_ff  <= s1_use_mem_ff ? mem_rd_data : s1_rdata_ff;
         out_status_ff <= s1_status_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_kind_ff;
   assign rsp_bus.rom_address = out_rom_ff;
   assign rsp_bus.read_data   = out_rdata_ff;
   assign rsp_bus.status      = out_status_ff;

endmodule
